// ===== rtl/core/adb_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ADB_FRAME_RECEIVER_MACROS_SVH
`define ADB_FRAME_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADBFR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADBFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/adbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// adbfr_pkg
// Shared types and constants for the bus reply frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package adbfr_pkg;

	// Field widths.
	localparam int DUR_W       = 8;
	localparam int CELL_W      = 9;
	localparam int CFG_W       = 9;
	localparam int CFG_ADDR_W  = 3;
	localparam int REG_DATA_W  = 16;
	localparam int STATUS_W    = 3;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;

	// Default frame length in data bits.
	localparam int DATA_BITS_DEF = 16;

	// Register reset values.
	localparam logic [DUR_W-1:0]  START_LOW_MIN_RST = 8'd18;
	localparam logic [DUR_W-1:0]  START_LOW_MAX_RST = 8'd55;
	localparam logic [DUR_W-1:0]  SYNC_HIGH_MIN_RST = 8'd40;
	localparam logic [DUR_W-1:0]  SYNC_HIGH_MAX_RST = 8'd90;
	localparam logic [CELL_W-1:0] CELL_MIN_RST      = 9'd70;
	localparam logic [CELL_W-1:0] CELL_MAX_RST      = 9'd130;
	localparam logic [DUR_W-1:0]  STOP_LOW_MAX_RST  = 8'd85;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_START = 3'd1,
		ST_SYNC  = 3'd2,
		ST_BIT   = 3'd3,
		ST_STOP  = 3'd4
	} status_t;

	// Input command codes.
	typedef enum logic {
		CMD_ARM   = 1'b0,
		CMD_PULSE = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_START_LOW_MIN = 3'd0,
		CFG_START_LOW_MAX = 3'd1,
		CFG_SYNC_HIGH_MIN = 3'd2,
		CFG_SYNC_HIGH_MAX = 3'd3,
		CFG_CELL_MIN      = 3'd4,
		CFG_CELL_MAX      = 3'd5,
		CFG_STOP_LOW_MAX  = 3'd6
	} cfg_idx_t;

	// Timing windows.
	typedef struct packed {
		logic [DUR_W-1:0]  start_low_min;
		logic [DUR_W-1:0]  start_low_max;
		logic [DUR_W-1:0]  sync_high_min;
		logic [DUR_W-1:0]  sync_high_max;
		logic [CELL_W-1:0] cell_min;
		logic [CELL_W-1:0] cell_max;
		logic [DUR_W-1:0]  stop_low_max;
	} cfg_t;

	// Decision for one pulse, from the decoder to the control logic.
	typedef struct packed {
		logic              emit;
		status_t           status;
		logic [CELL_W-1:0] fault;
		logic              clear;
		logic              start_ok;
		logic              shift_en;
		logic              bit_val;
	} dec_t;

endpackage

`default_nettype wire

// ===== rtl/core/adbfr_decode.sv =====
// ----------------------------------------------------------------------------
// adbfr_decode
// Classifies one pulse against the timing windows at the current frame
// position and gives the result and state update that it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module adbfr_decode #(
	parameter int DATA_BITS = adbfr_pkg::DATA_BITS_DEF,
	parameter int POS_W     = $clog2(DATA_BITS + 2)
) (
	input  wire  [POS_W-1:0]            pos,
	input  wire                         cmd,
	input  wire  [adbfr_pkg::DUR_W-1:0] low_us,
	input  wire  [adbfr_pkg::DUR_W-1:0] high_us,
	input  wire  adbfr_pkg::cfg_t       cfg,
	output adbfr_pkg::dec_t             dec
);
	import adbfr_pkg::*;

	logic              at_start;
	logic              at_data;
	logic [CELL_W-1:0] cell_sum;
	logic [CELL_W-1:0] low_ext;
	logic [CELL_W-1:0] high_ext;

	// Where in the frame the next pulse falls.
	assign at_start = (pos == '0);
	assign at_data  = (pos <= POS_W'(DATA_BITS));

	assign low_ext  = {1'b0, low_us};
	assign high_ext = {1'b0, high_us};
	assign cell_sum = low_ext + high_ext;

	// Window checks for the current position.
	always_comb begin
		dec          = '0;
		dec.status   = ST_OK;
		dec.bit_val  = (low_us < high_us);
		if (cmd == CMD_ARM) begin
			dec.clear = 1'b1;
		end else if (at_start) begin
			if (low_us == '0 || low_us > cfg.start_low_max || low_us < cfg.start_low_min) begin
				dec.emit   = 1'b1;
				dec.status = ST_START;
				dec.fault  = low_ext;
			end else if (high_us == '0 || high_us > cfg.sync_high_max
					|| high_us < cfg.sync_high_min) begin
				dec.emit   = 1'b1;
				dec.status = ST_SYNC;
				dec.fault  = high_ext;
			end else begin
				dec.start_ok = 1'b1;
			end
		end else if (at_data) begin
			if (low_us == '0 || high_us == '0) begin
				dec.emit   = 1'b1;
				dec.status = ST_BIT;
			end else if (cell_sum < cfg.cell_min || cell_sum > cfg.cell_max) begin
				dec.emit   = 1'b1;
				dec.status = ST_BIT;
				dec.fault  = cell_sum;
			end else begin
				dec.shift_en = 1'b1;
			end
		end else begin
			dec.emit = 1'b1;
			if (low_us == '0 || low_us > cfg.stop_low_max) begin
				dec.status = ST_STOP;
				dec.fault  = low_ext;
			end
		end
		// Any result ends the frame.
		if (dec.emit) begin
			dec.clear = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/adb_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// adb_frame_receiver
// Decodes a 16-bit register reply frame of a single-wire bus from measured
// pulse widths and reports one result per frame or at the first error.
// ----------------------------------------------------------------------------
// The receiver takes one pulse item per clock cycle; the pulse that ends a
// frame passes the input register and then the result register before its
// result is shown. The input keeps taking items while a result waits to be
// taken; only a result that cannot leave because the output is stalled holds
// the pulse behind it. An arm item (tuser low) restarts the frame without a
// result. Configuration writes must be made while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module adb_frame_receiver #(
	parameter int DATA_BITS = adbfr_pkg::DATA_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// Configuration write port.
	input  wire                                cfg_we,
	input  wire  [adbfr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire  [adbfr_pkg::CFG_W-1:0]        cfg_wdata,
	// Pulse stream.
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [adbfr_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] low_us, [15:8] high_us
	input  wire                                s_tuser,  // [0] cmd
	// Result stream.
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [adbfr_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [15:0] reg_data, [24:16] fault_timing
	output logic [adbfr_pkg::STATUS_W-1:0]     m_tuser   // [2:0] status
);
	import adbfr_pkg::*;

	localparam int POS_W   = $clog2(DATA_BITS + 2);
	localparam int SHIFT_W = (DATA_BITS > REG_DATA_W) ? DATA_BITS : REG_DATA_W;

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic                  cmd_s1;
	logic [DUR_W-1:0]      low_s1;
	logic [DUR_W-1:0]      high_s1;
	logic [POS_W-1:0]      pos_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [REG_DATA_W-1:0] out_data_q;
	logic [CELL_W-1:0]     out_fault_q;
	dec_t                  dec;
	logic                  out_free;
	logic                  advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_min <= START_LOW_MIN_RST;
			cfg_q.start_low_max <= START_LOW_MAX_RST;
			cfg_q.sync_high_min <= SYNC_HIGH_MIN_RST;
			cfg_q.sync_high_max <= SYNC_HIGH_MAX_RST;
			cfg_q.cell_min      <= CELL_MIN_RST;
			cfg_q.cell_max      <= CELL_MAX_RST;
			cfg_q.stop_low_max  <= STOP_LOW_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_START_LOW_MIN: cfg_q.start_low_min <= cfg_wdata[DUR_W-1:0];
				CFG_START_LOW_MAX: cfg_q.start_low_max <= cfg_wdata[DUR_W-1:0];
				CFG_SYNC_HIGH_MIN: cfg_q.sync_high_min <= cfg_wdata[DUR_W-1:0];
				CFG_SYNC_HIGH_MAX: cfg_q.sync_high_max <= cfg_wdata[DUR_W-1:0];
				CFG_CELL_MIN:      cfg_q.cell_min      <= cfg_wdata;
				CFG_CELL_MAX:      cfg_q.cell_max      <= cfg_wdata;
				CFG_STOP_LOW_MAX:  cfg_q.stop_low_max  <= cfg_wdata[DUR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input register moves on unless its result cannot be stored.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!dec.emit || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			low_s1  <= s_tdata[DUR_W-1:0];
			high_s1 <= s_tdata[2*DUR_W-1:DUR_W];
		end
	end

	adbfr_decode #(
		.DATA_BITS (DATA_BITS),
		.POS_W     (POS_W)
	) u_decode (
		.pos     (pos_q),
		.cmd     (cmd_s1),
		.low_us  (low_s1),
		.high_us (high_s1),
		.cfg     (cfg_q),
		.dec     (dec)
	);

	// Frame position and received word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			shift_q <= '0;
		end else if (advance) begin
			if (dec.clear) begin
				pos_q   <= '0;
				shift_q <= '0;
			end else if (dec.start_ok) begin
				pos_q   <= POS_W'(1);
				shift_q <= '0;
			end else if (dec.shift_en) begin
				pos_q   <= pos_q + POS_W'(1);
				shift_q <= {shift_q[SHIFT_W-2:0], dec.bit_val};
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && dec.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.emit) begin
			out_status_q <= dec.status;
			out_fault_q  <= dec.fault;
			out_data_q   <= (dec.status == ST_OK) ? shift_q[REG_DATA_W-1:0] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(OUT_TDATA_W - CELL_W - REG_DATA_W){1'b0}}, out_fault_q, out_data_q};

endmodule

`default_nettype wire

// ===== rtl/core/adbfr_checker.sv =====
// ----------------------------------------------------------------------------
// adbfr_checker
// Checks the result stream of the frame receiver over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adb_frame_receiver_macros.svh"

module adbfr_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                m_tvalid,
	input wire                                m_tready,
	input wire [adbfr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input wire [adbfr_pkg::STATUS_W-1:0]      m_tuser
);
	import adbfr_pkg::*;

	// A successful frame carries no fault timing.
	`ADBFR_ASSERT_SAME(a_ok_no_fault, m_tvalid && m_tuser == ST_OK, m_tdata[24:16] == '0, "ok result with fault timing")

	// An error result carries no register word.
	`ADBFR_ASSERT_SAME(a_err_no_data, m_tvalid && m_tuser != ST_OK, m_tdata[15:0] == '0, "error result with data")

	// Start, sync and stop faults are single durations and fit in eight bits.
	`ADBFR_ASSERT_SAME(a_dur_fault_narrow, m_tvalid && (m_tuser == ST_START || m_tuser == ST_SYNC || m_tuser == ST_STOP), m_tdata[24] == 1'b0, "duration fault too wide")

	// A stalled result holds until it is taken.
	`ADBFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind adb_frame_receiver adbfr_checker u_checker (.*);

`default_nettype wire
